// ===== rtl/core/serpent_pkg.sv =====
// ----------------------------------------------------------------------------
// serpent_pkg
// shared types, s-box tables and round functions for the serpent core
// ----------------------------------------------------------------------------
package serpent_pkg;

  localparam int KeyWords = 132;
  localparam int Rounds   = 32;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ENCRYPT = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;

  // forward s-box lookup, box 0..7
  function automatic logic [3:0] sbox_fwd(input logic [2:0] box, input logic [3:0] x);
    logic [63:0] t;
    begin
      case (box)
        3'd0: t = 64'hC90724DEB56A1F83;
        3'd1: t = 64'h43D68EB1A50972CF;
        3'd2: t = 64'h25B04E1DFAC39768;
        3'd3: t = 64'hE57A421D369C8BF0;
        3'd4: t = 64'hD7E9A4526B0C38F1;
        3'd5: t = 64'h176D8E30C9A4B25F;
        3'd6: t = 64'h0A3DF19EB6485C27;
        default: t = 64'h6539AC47B28E0FD1;
      endcase
      sbox_fwd = t[x*4 +: 4];
    end
  endfunction

  // inverse s-box lookup by search over the forward table
  function automatic logic [3:0] sbox_inv(input logic [2:0] box, input logic [3:0] y);
    logic [3:0] r;
    begin
      r = 4'd0;
      for (int i = 0; i < 16; i++) begin
        if (sbox_fwd(box, 4'(i)) == y) r = 4'(i);
      end
      sbox_inv = r;
    end
  endfunction

  // bitslice s-box layer over a 128-bit state
  function automatic blk_t sbox_layer(input logic [2:0] box, input logic inv, input blk_t s);
    blk_t o;
    logic [3:0] n, v;
    begin
      o = '0;
      for (int b = 0; b < 32; b++) begin
        n = {s[96+b], s[64+b], s[32+b], s[b]};
        v = inv ? sbox_inv(box, n) : sbox_fwd(box, n);
        o[b] = v[0]; o[32+b] = v[1]; o[64+b] = v[2]; o[96+b] = v[3];
      end
      sbox_layer = o;
    end
  endfunction

  function automatic word_t rol(input word_t x, input int n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  function automatic blk_t lin_fwd(input blk_t s);
    word_t w0, w1, w2, w3;
    begin
      {w3, w2, w1, w0} = s;
      w0 = rol(w0, 13); w2 = rol(w2, 3);
      w1 = w1 ^ w0 ^ w2; w3 = w3 ^ w2 ^ (w0 << 3);
      w1 = rol(w1, 1); w3 = rol(w3, 7);
      w0 = w0 ^ w1 ^ w3; w2 = w2 ^ w3 ^ (w1 << 7);
      w0 = rol(w0, 5); w2 = rol(w2, 22);
      lin_fwd = {w3, w2, w1, w0};
    end
  endfunction

  function automatic blk_t lin_inv(input blk_t s);
    word_t w0, w1, w2, w3;
    begin
      {w3, w2, w1, w0} = s;
      w2 = rol(w2, 10); w0 = rol(w0, 27);
      w2 = w2 ^ w3 ^ (w1 << 7); w0 = w0 ^ w1 ^ w3;
      w3 = rol(w3, 25); w1 = rol(w1, 31);
      w3 = w3 ^ w2 ^ (w0 << 3); w1 = w1 ^ w0 ^ w2;
      w2 = rol(w2, 29); w0 = rol(w0, 19);
      lin_inv = {w3, w2, w1, w0};
    end
  endfunction

  typedef struct packed {
    logic valid;
    logic dec;
  } ctl_t;

endpackage

// ===== rtl/core/serpent_round.sv =====
// ----------------------------------------------------------------------------
// serpent_round
// one registered pipeline stage: a single encrypt or decrypt round
// ----------------------------------------------------------------------------
module serpent_round #(
  parameter int Idx = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  serpent_pkg::ctl_t   ctl_in,
  input  serpent_pkg::blk_t   blk_in,
  input  serpent_pkg::blk_t   key_a,
  input  serpent_pkg::blk_t   key_b,
  output serpent_pkg::ctl_t   ctl_out,
  output serpent_pkg::blk_t   blk_out
);
  localparam logic [2:0] EncBox = 3'(Idx % 8);
  localparam logic [2:0] DecBox = 3'((31 - Idx) % 8);
  localparam bit         Last   = (Idx == 31);
  localparam bit         First  = (Idx == 0);

  serpent_pkg::ctl_t ctl_r;
  serpent_pkg::blk_t blk_r, blk_nxt, e, d;

  // encrypt: key r, sbox, transform (key 32 at the end)
  // decrypt: (key 32 first), inverse transform unless first, inv sbox, key
  always_comb begin
    e = serpent_pkg::sbox_layer(EncBox, 1'b0, blk_in ^ key_a);
    e = Last ? (e ^ key_b) : serpent_pkg::lin_fwd(e);
    d = First ? (blk_in ^ key_b) : serpent_pkg::lin_inv(blk_in);
    d = serpent_pkg::sbox_layer(DecBox, 1'b1, d) ^ key_a;
    blk_nxt = ctl_in.dec ? d : e;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_in;
    end
    if (adv) blk_r <= blk_nxt;
  end

  assign ctl_out = ctl_r;
  assign blk_out = blk_r;
endmodule

// ===== rtl/core/serpent_block_cipher.sv =====
// ----------------------------------------------------------------------------
// serpent_block_cipher
// 32-round serpent encrypt/decrypt core, one round per pipeline stage
// ----------------------------------------------------------------------------
// usage: load the 132 round-key words with operation 0 (key_index 0..131)
// before sending blocks; loads outside that range and operation 3 are
// dropped with no result. encrypt (1) and decrypt (2) transactions each
// give one result on the out_ channel.
// pipeline: each block passes through the 32 round stage registers before
// out_valid rises; throughput one block per cycle while out_ is not held.
// key words sit in flops so every stage reads its own round key in the
// same cycle.
// a key load takes effect at once, also for blocks still in the pipe; the
// user loads keys while the pipe is empty, which the block does not enforce.
// reset clears all stage valid bits; key words stay undefined until written.
// stall: when out_ is held, the whole pipe freezes and in_ready drops only
// if the final stage holds an undelivered result.
// ----------------------------------------------------------------------------
module serpent_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_low,
  input  logic [63:0] in_block_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_low,
  output logic [63:0] out_result_high
);
  localparam int N = serpent_pkg::Rounds;

  logic [31:0] key_r [serpent_pkg::KeyWords];
  serpent_pkg::ctl_t ctl  [N+1];
  serpent_pkg::blk_t blk  [N+1];
  serpent_pkg::blk_t rk   [N+1];
  logic adv, acc;

  // pipe moves unless the last stage holds a result not taken
  assign adv      = !ctl[N].valid || out_ready;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  // key store writes
  always_ff @(posedge clk) begin
    if (acc && in_operation == serpent_pkg::OP_LOAD &&
        in_key_index < 8'(serpent_pkg::KeyWords)) begin
      key_r[in_key_index] <= in_key_word;
    end
  end

  // round keys as 128-bit words
  for (genvar r = 0; r <= N; r++) begin : g_rk
    assign rk[r] = {key_r[4*r+3], key_r[4*r+2], key_r[4*r+1], key_r[4*r]};
  end

  // stage 0 input
  assign ctl[0].valid = in_valid && (in_operation == serpent_pkg::OP_ENCRYPT ||
                                     in_operation == serpent_pkg::OP_DECRYPT);
  assign ctl[0].dec   = (in_operation == serpent_pkg::OP_DECRYPT);
  assign blk[0]       = {in_block_high, in_block_low};

  // round stages; decrypt stage i uses round key 31-i, decrypt 0 also key 32
  for (genvar i = 0; i < N; i++) begin : g_st
    serpent_pkg::blk_t ka, kb;
    assign ka = ctl[i].dec ? rk[N-1-i] : rk[i];
    assign kb = rk[N];
    serpent_round #(.Idx(i)) u_round (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .ctl_in(ctl[i]), .blk_in(blk[i]), .key_a(ka), .key_b(kb),
      .ctl_out(ctl[i+1]), .blk_out(blk[i+1])
    );
  end

  assign out_valid       = ctl[N].valid;
  assign out_result_low  = blk[N][63:0];
  assign out_result_high = blk[N][127:64];

  // assertions
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_low))
    else $error("result changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_valid && in_operation == serpent_pkg::OP_LOAD |=> !ctl[1].valid)
    else $error("key load entered pipe");
endmodule
